// ===== sv/pat_pkg.sv =====
`timescale 1ns / 1ps

package pat_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int RESULT_MAX   = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 3;

    localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UPDATE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TRAVERSE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_UPDATE,
        OP_TRAVERSE,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         found_index;
        logic signed [DATA_W-1:0] entry_value;
        logic [CNT_W-1:0]         element_count;
        logic                     last;
    } t_out;

    typedef struct packed {
        t_op                      op;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_value;
    } t_cmd;

endpackage

// ===== sv/pat_front.sv =====
`timescale 1ns / 1ps

module pat_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pat_pkg::t_in  i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output pat_pkg::t_cmd o_cmd
);
    import pat_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // action decode, unused codes become a no-op
    always_comb begin
        n_cmd.position   = i_data.position;
        n_cmd.data_value = i_data.data_value;
        unique case (i_data.action)
            ACT_INSERT:   n_cmd.op = OP_INSERT;
            ACT_DELETE:   n_cmd.op = OP_DELETE;
            ACT_SEARCH:   n_cmd.op = OP_SEARCH;
            ACT_UPDATE:   n_cmd.op = OP_UPDATE;
            ACT_TRAVERSE: n_cmd.op = OP_TRAVERSE;
            default:      n_cmd.op = OP_NOP;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== sv/pat_queue.sv =====
`timescale 1ns / 1ps

module pat_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  pat_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output pat_pkg::t_cmd o_pop_cmd
);
    import pat_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== sv/pat_back.sv =====
`timescale 1ns / 1ps

module pat_back #(
    parameter int CAPACITY = pat_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  pat_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output pat_pkg::t_out o_data
);
    import pat_pkg::*;

    localparam int HOLD  = (CAPACITY < RESULT_MAX) ? CAPACITY : RESULT_MAX;
    localparam int IDX_W = $clog2(HOLD);

    t_state                   r_state;
    t_state                   n_state;
    t_cmd                     r_cmd;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic signed [DATA_W-1:0] r_cells [HOLD];
    logic signed [DATA_W-1:0] n_cells [HOLD];
    logic [HOLD-1:0]          r_match;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_out_valid;
    t_out                     r_out;

    logic             out_free;
    logic [CNT_W-1:0] pos_ext;
    logic             walk_last;
    logic             hit;
    logic [POS_W-1:0] hit_idx;
    logic             emit;
    t_out             res;
    logic             do_insert;
    logic             do_delete;
    logic             do_update;

    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign pos_ext     = CNT_W'(r_cmd.position);
    assign walk_last   = (CNT_W'(r_idx) + 1'b1 == r_count);

    // lowest matching cell wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = HOLD - 1; j >= 0; j--) begin
            if (r_match[j]) begin
                hit     = 1'b1;
                hit_idx = POS_W'(j);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_cmd.op == OP_SEARCH) begin
                    n_state = S_FIND;
                end else if (r_cmd.op == OP_TRAVERSE && r_count != '0) begin
                    n_state = S_WALK;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (out_free) n_state = S_IDLE;
            end
            S_WALK: begin
                if (out_free && walk_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and list edits
    always_comb begin
        emit              = 1'b0;
        do_insert         = 1'b0;
        do_delete         = 1'b0;
        do_update         = 1'b0;
        n_count           = r_count;
        res.status        = STAT_OK;
        res.found_index   = '0;
        res.entry_value   = '0;
        res.last          = 1'b1;
        unique case (r_state)
            S_EXEC: begin
                emit = out_free;
                unique case (r_cmd.op)
                    OP_INSERT: begin
                        if (r_count >= CNT_W'(HOLD)) begin
                            res.status = STAT_FULL;
                        end else if (pos_ext > r_count) begin
                            res.status = STAT_BADPOS;
                        end else begin
                            do_insert = out_free;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (pos_ext >= r_count) begin
                            res.status = STAT_BADPOS;
                        end else begin
                            do_delete = out_free;
                            n_count   = r_count - 1'b1;
                        end
                    end
                    OP_UPDATE: begin
                        if (pos_ext >= r_count) begin
                            res.status = STAT_BADPOS;
                        end else begin
                            do_update = out_free;
                        end
                    end
                    OP_TRAVERSE: begin
                        if (r_count == '0) begin
                            res.status = STAT_EMPTY;
                        end else begin
                            emit = 1'b0;
                        end
                    end
                    OP_SEARCH: emit = 1'b0;
                    default: ;
                endcase
                if (!out_free) n_count = r_count;
            end
            S_FIND: begin
                emit            = out_free;
                res.status      = hit ? STAT_OK : STAT_NOTFOUND;
                res.found_index = hit_idx;
            end
            S_WALK: begin
                emit            = out_free;
                res.found_index = POS_W'(r_idx);
                res.entry_value = r_cells[r_idx];
                res.last        = walk_last;
            end
            default: ;
        endcase
        res.element_count = n_count;
    end

    // per-cell shift and write
    for (genvar g = 0; g < HOLD; g++) begin : g_cell
        logic signed [DATA_W-1:0] below;
        logic signed [DATA_W-1:0] above;
        if (g == 0) begin : g_first
            assign below = r_cells[0];
        end else begin : g_mid
            assign below = r_cells[g-1];
        end
        if (g == HOLD - 1) begin : g_top
            assign above = r_cells[g];
        end else begin : g_low
            assign above = r_cells[g+1];
        end
        always_comb begin
            n_cells[g] = r_cells[g];
            if (do_insert) begin
                if (CNT_W'(g) == pos_ext) begin
                    n_cells[g] = r_cmd.data_value;
                end else if (CNT_W'(g) > pos_ext) begin
                    n_cells[g] = below;
                end
            end else if (do_delete) begin
                if (CNT_W'(g) >= pos_ext) n_cells[g] = above;
            end else if (do_update) begin
                if (CNT_W'(g) == pos_ext) n_cells[g] = r_cmd.data_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        if (emit) r_out <= res;
        if (r_state == S_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        if (r_state == S_EXEC) begin
            r_idx <= '0;
            for (int j = 0; j < HOLD; j++) begin
                r_match[j] <= (r_cells[j] == r_cmd.data_value) && (CNT_W'(j) < r_count);
            end
        end else if (r_state == S_WALK && out_free) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// ===== sv/positional_array_table.sv =====
`timescale 1ns / 1ps
// path: a request passes the front register, the command queue and the back-end
// command register; the result is registered in S_EXEC, S_FIND (search) or S_WALK (traverse)
// the back end takes one request at a time; traverse yields one result per cycle unless stalled
// a 2-entry command queue lets the front keep taking transfers while the back is busy
// reset: synchronous active-low, clears count, queue and handshake state; entries undefined

module positional_array_table #(
    parameter int CAPACITY = pat_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pat_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pat_pkg::t_out o_data
);
    import pat_pkg::*;

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    pat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    pat_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    pat_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== tb/sv/tb_positional_array_table.sv =====
`timescale 1ns / 1ps

module tb_positional_array_table;
    import pat_pkg::*;

    localparam int HOLD_MAX     = (CAPACITY_DEF < RESULT_MAX) ? CAPACITY_DEF : RESULT_MAX;
    localparam int RANDOM_ITEMS = 227;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 2_000_000;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef enum int {
        MIX_GROW,
        MIX_BALANCED,
        MIX_SHRINK
    } t_mix;

    // shadow copy of the list plus the queue of results it predicts
    class list_shadow;
        logic signed [DATA_W-1:0] cells [HOLD_MAX];
        int   held;
        t_out expected_results [$];
        int   errors;
        int   requests;
        int   checked;
        int   walk_results;
        int   peak;
        int   status_seen [8];

        function new();
            held = 0;
            errors = 0;
            requests = 0;
            checked = 0;
            walk_results = 0;
            peak = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void push_result(logic [STAT_W-1:0] st, int idx,
                                  logic signed [DATA_W-1:0] val, logic fin);
            t_out r;
            r.status        = st;
            r.found_index   = POS_W'(idx);
            r.entry_value   = val;
            r.element_count = CNT_W'(held);
            r.last          = fin;
            expected_results.push_back(r);
        endfunction

        function void note_request(t_in req);
            int  i;
            int  pos;
            int  hit_idx;
            bit  hit;
            pos = int'(req.position);
            requests++;
            case (req.action)
                ACT_INSERT: begin
                    if (held >= HOLD_MAX) begin
                        push_result(STAT_FULL, 0, '0, 1'b1);
                    end else if (pos > held) begin
                        push_result(STAT_BADPOS, 0, '0, 1'b1);
                    end else begin
                        for (i = held; i > pos; i--) cells[i] = cells[i-1];
                        cells[pos] = req.data_value;
                        held++;
                        if (held > peak) peak = held;
                        push_result(STAT_OK, 0, '0, 1'b1);
                    end
                end
                ACT_DELETE: begin
                    if (pos >= held) begin
                        push_result(STAT_BADPOS, 0, '0, 1'b1);
                    end else begin
                        for (i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
                        held--;
                        push_result(STAT_OK, 0, '0, 1'b1);
                    end
                end
                ACT_SEARCH: begin
                    hit = 1'b0;
                    hit_idx = 0;
                    for (i = 0; i < held; i++) begin
                        if (!hit && cells[i] == req.data_value) begin
                            hit = 1'b1;
                            hit_idx = i;
                        end
                    end
                    if (hit) push_result(STAT_OK, hit_idx, '0, 1'b1);
                    else     push_result(STAT_NOTFOUND, 0, '0, 1'b1);
                end
                ACT_UPDATE: begin
                    if (pos >= held) begin
                        push_result(STAT_BADPOS, 0, '0, 1'b1);
                    end else begin
                        cells[pos] = req.data_value;
                        push_result(STAT_OK, 0, '0, 1'b1);
                    end
                end
                ACT_TRAVERSE: begin
                    if (held == 0) begin
                        push_result(STAT_EMPTY, 0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < held; i++)
                            push_result(STAT_OK, i, cells[i], (i + 1 == held));
                        walk_results += held;
                    end
                end
                default: begin
                    // unused action codes leave the list alone
                    push_result(STAT_OK, 0, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing outstanding: %p", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.found_index !== want.found_index) begin
                $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
                errors++;
            end
            if (got.entry_value !== want.entry_value) begin
                $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
                errors++;
            end
            if (got.element_count !== want.element_count) begin
                $error("element_count: expected %0d, got %0d",
                       want.element_count, got.element_count);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    list_shadow sb;
    int results_seen = 0;
    int cycle_count  = 0;
    int burst_left   = 0;

    positional_array_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25 && sb.held > 0) return sb.cells[$urandom_range(0, sb.held - 1)];
        if (r < 35) begin
            case ($urandom_range(0, 3))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // mostly in range, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(logic [ACT_W-1:0] act);
        int span;
        span = (act == ACT_INSERT) ? sb.held : sb.held - 1;
        if (span > 31) span = 31;
        if (span < 0 || $urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, span));
    endfunction

    function automatic t_in make_request(t_mix mix);
        t_in req;
        int  r;
        int  w_ins;
        int  w_del;
        int  w_srch;
        int  w_upd;
        int  w_trav;
        case (mix)
            MIX_GROW:     begin w_ins = 70; w_del = 5;  w_srch = 10; w_upd = 7;  w_trav = 5; end
            MIX_SHRINK:   begin w_ins = 10; w_del = 60; w_srch = 10; w_upd = 8;  w_trav = 9; end
            default:      begin w_ins = 30; w_del = 25; w_srch = 15; w_upd = 15; w_trav = 12; end
        endcase
        r = $urandom_range(0, 99);
        if (r < w_ins)                                  req.action = ACT_INSERT;
        else if (r < w_ins + w_del)                     req.action = ACT_DELETE;
        else if (r < w_ins + w_del + w_srch)            req.action = ACT_SEARCH;
        else if (r < w_ins + w_del + w_srch + w_upd)    req.action = ACT_UPDATE;
        else if (r < w_ins + w_del + w_srch + w_upd + w_trav) req.action = ACT_TRAVERSE;
        else                                            req.action = ACT_W'($urandom_range(5, 7));
        req.position   = pick_position(req.action);
        req.data_value = pick_value();
        return req;
    endfunction

    // valid stays up across back-to-back requests; it only drops for a gap
    task automatic send_request(t_in req);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            if ($urandom_range(0, 99) < 3) burst_left = 20;
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(req);
    endtask

    task automatic send_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
        t_in req;
        req.action     = act;
        req.position   = pos;
        req.data_value = val;
        send_request(req);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_data);
            results_seen <= results_seen + 1;
        end
    end

    initial begin : sink_pacing
        int dur;
        bit level;
        int holds_done;
        holds_done = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // long hold-offs let the command queue fill and back up the input
            if ((holds_done == 0 && results_seen >= 40) ||
                (holds_done == 1 && results_seen >= 600)) begin
                level = 1'b0;
                dur = LONG_HOLD;
                holds_done++;
            end else if ($urandom_range(0, 99) < 5) begin
                level = 1'b1;
                dur = $urandom_range(30, 80);
            end else if ($urandom_range(0, 99) < 60) begin
                level = 1'b1;
                dur = $urandom_range(1, 6);
            end else begin
                level = 1'b0;
                dur = pick_gap() + 1;
            end
            i_ready <= level;
            repeat (dur) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_mix mix;
        int   n;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        send_op(ACT_TRAVERSE, 5'd0,  32'sd0);
        send_op(ACT_SEARCH,   5'd0,  32'sd0);
        send_op(ACT_DELETE,   5'd0,  32'sd0);
        send_op(ACT_UPDATE,   5'd0,  WORD_MAX);
        send_op(ACT_INSERT,   5'd1,  32'sd7);
        // append, front insert, beyond the end
        send_op(ACT_INSERT,   5'd0,  WORD_MAX);
        send_op(ACT_INSERT,   5'd1,  WORD_MIN);
        send_op(ACT_INSERT,   5'd0,  -32'sd1);
        send_op(ACT_INSERT,   5'd31, 32'sd3);
        send_op(ACT_SEARCH,   5'd0,  WORD_MIN);
        send_op(ACT_SEARCH,   5'd0,  32'sd12345);
        send_op(ACT_UPDATE,   5'd1,  32'sd0);
        // position equal to the count is out of range for update and delete
        send_op(ACT_UPDATE,   5'd3,  32'sd9);
        send_op(ACT_DELETE,   5'd3,  32'sd0);
        send_op(ACT_TRAVERSE, 5'd31, WORD_MIN);
        send_op(3'd5,         5'd0,  32'sd0);
        send_op(3'd6,         5'd2,  32'sd1);
        send_op(3'd7,         5'd31, -32'sd1);
        send_op(ACT_DELETE,   5'd0,  32'sd0);
        send_op(ACT_DELETE,   5'd1,  32'sd0);
        // duplicates: search must report the lowest index
        send_op(ACT_INSERT,   5'd1,  32'sd0);
        send_op(ACT_SEARCH,   5'd0,  32'sd0);
        send_op(ACT_TRAVERSE, 5'd0,  32'sd0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < 80)       mix = MIX_GROW;
            else if (n < 130) mix = MIX_BALANCED;
            else if (n < 180) mix = MIX_SHRINK;
            else if (n < 220) mix = MIX_GROW;
            else              mix = MIX_BALANCED;
            send_request(make_request(mix));
        end
        i_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d results, %0d from traversals, peak fill %0d",
                 sb.requests, sb.checked, sb.walk_results, sb.peak);
        $display("status tally: ok %0d, full %0d, bad position %0d, not found %0d, empty %0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL],
                 sb.status_seen[STAT_BADPOS], sb.status_seen[STAT_NOTFOUND],
                 sb.status_seen[STAT_EMPTY]);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
